// ===== rtl/rv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv_pkg: shared types and constants of the radial vignette pixel block
// Field widths, register codes, reset values and the channel word type.
// ----------------------------------------------------------------------------
package rv_pkg;

	localparam int IDX_W     = 12;   // pixel row / column index
	localparam int CH_W      = 8;    // one color channel
	localparam int REG_W     = 13;   // configuration register width
	localparam int NCH       = 3;    // red, green, blue
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd1;

	localparam logic [REG_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [REG_W-1:0] WIDTH_RST  = 13'd640;

	typedef logic [CH_W-1:0] ch_t;
	typedef ch_t [NCH-1:0] rgb_t;   // index 0 red, 1 green, 2 blue

endpackage
`default_nettype wire

// ===== rtl/rv_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv_sqrt_cell: one root bit of the distance square root
// Restoring square root step; consumes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module rv_sqrt_cell #(
	parameter int RW = 21
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_v,
	input  wire logic [2*RW-1:0]   in_rad,
	input  wire logic [RW+1:0]     in_rem,
	input  wire logic [RW-1:0]     in_root,
	input  wire rv_pkg::rgb_t      in_rgb,
	output logic                   out_v_q,
	output logic [2*RW-1:0]        out_rad_q,
	output logic [RW+1:0]          out_rem_q,
	output logic [RW-1:0]          out_root_q,
	output rv_pkg::rgb_t           out_rgb_q
);

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fits;

	assign rem_sh = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
	assign trial  = {in_root, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		out_rad_q  <= {in_rad[2*RW-3:0], 2'b00};
		out_rem_q  <= fits ? rem_sh - trial : rem_sh;
		out_root_q <= {in_root[RW-2:0], fits};
		out_rgb_q  <= in_rgb;
	end

endmodule
`default_nettype wire

// ===== rtl/rv_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv_div_cell: one quotient bit of the channel scaling division
// Compare and subtract the shifted radius from all three channel remainders.
// ----------------------------------------------------------------------------
module rv_div_cell #(
	parameter int K     = 7,
	parameter int N_W   = 29,
	parameter int DEN_W = 21
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [DEN_W-1:0]                     den,
	input  wire logic                                 in_v,
	input  wire logic [rv_pkg::NCH-1:0][N_W-1:0]      in_rem,
	input  wire rv_pkg::rgb_t                         in_q,
	output logic                                      out_v_q,
	output logic [rv_pkg::NCH-1:0][N_W-1:0]           out_rem_q,
	output rv_pkg::rgb_t                              out_q_q
);

	logic [N_W-1:0] den_sh;

	assign den_sh = N_W'(den) << K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= in_v;
		end
	end

	// advance all channels together, one quotient bit each; a zero radius
	// keeps every quotient bit clear
	always_ff @(posedge clk) begin
		for (int i = 0; i < rv_pkg::NCH; i++) begin
			if ((den != '0) && (in_rem[i] >= den_sh)) begin
				out_rem_q[i] <= in_rem[i] - den_sh;
				out_q_q[i]   <= {in_q[i][rv_pkg::CH_W-2:0], 1'b1};
			end else begin
				out_rem_q[i] <= in_rem[i];
				out_q_q[i]   <= {in_q[i][rv_pkg::CH_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/radial_vignette_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radial_vignette_pixel: radial vignette applied to one pixel per clock
// Attenuates each color channel linearly with distance from the image center.
// ----------------------------------------------------------------------------
// Usage:
//   Input: raise start with pixel_row, pixel_col and the three channels; the
//   word is taken at every edge with start high (busy is always low, so a
//   new pixel can enter in every cycle).
//   Output: done pulses for one cycle with red_out/green_out/blue_out valid.
//   The receiver cannot stall; results leave in input order.
//   Config: cfg_we with cfg_idx (0 height, 1 width) and cfg_wdata writes a
//   register; write only while no pixel is in flight.
// Pipeline: three front stages, then the chain of square root cells
//   (FRAC_BITS + 13 of them, one root bit each), then one multiply and the
//   eight cells of the quotient chain.
// Throughput: one pixel per clock; every cell passes its word on each cycle.
// Reset: clears the valid bits of all stages and loads height 480, width 640.
// ----------------------------------------------------------------------------
module radial_vignette_pixel #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rv_pkg::IDX_W-1:0]      pixel_row,
	input  wire logic [rv_pkg::IDX_W-1:0]      pixel_col,
	input  wire logic [rv_pkg::CH_W-1:0]       red_in,
	input  wire logic [rv_pkg::CH_W-1:0]       green_in,
	input  wire logic [rv_pkg::CH_W-1:0]       blue_in,
	output logic                               done,
	output logic [rv_pkg::CH_W-1:0]            red_out,
	output logic [rv_pkg::CH_W-1:0]            green_out,
	output logic [rv_pkg::CH_W-1:0]            blue_out,
	input  wire logic                          cfg_we,
	input  wire logic [rv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rv_pkg::REG_W-1:0]      cfg_wdata
);

	localparam int IDX_W    = rv_pkg::IDX_W;
	localparam int CH_W     = rv_pkg::CH_W;
	localparam int NCH      = rv_pkg::NCH;
	localparam int SQ_W     = 2 * IDX_W + 1;
	localparam int RW       = (SQ_W + 2 * FRAC_BITS + 1) / 2;   // root bits
	localparam int RAD_W    = 2 * RW;
	localparam int RADIUS_W = rv_pkg::REG_W + FRAC_BITS;
	localparam int CMP_W    = (RW > RADIUS_W) ? RW : RADIUS_W;
	localparam int PROD_W   = CH_W + RADIUS_W;
	localparam int LAT      = RW + 4 + CH_W;

	// Configuration registers
	logic [rv_pkg::REG_W-1:0] height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= rv_pkg::HEIGHT_RST;
			width_q  <= rv_pkg::WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				rv_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				rv_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: absolute offsets from the center (halving rounds down)
	logic [IDX_W-1:0] cx, cy;
	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] dx_s1, dy_s1;
	rv_pkg::rgb_t     rgb_s1, rgb_s2, rgb_s3;
	logic [2*IDX_W-1:0] dx2_s2, dy2_s2;
	logic [SQ_W-1:0]  sq_s3;

	assign cx = width_q[rv_pkg::REG_W-1:1];
	assign cy = height_q[rv_pkg::REG_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= (pixel_col >= cx) ? pixel_col - cx : cx - pixel_col;
		dy_s1  <= (pixel_row >= cy) ? pixel_row - cy : cy - pixel_row;
		rgb_s1 <= '{blue_in, green_in, red_in};
		// Stage 2: square both offsets
		dx2_s2 <= dx_s1 * dx_s1;
		dy2_s2 <= dy_s1 * dy_s1;
		rgb_s2 <= rgb_s1;
		// Stage 3: squared distance
		sq_s3  <= SQ_W'(dx2_s2) + SQ_W'(dy2_s2);
		rgb_s3 <= rgb_s2;
	end

	// Square root chain: one root bit per cell, radicand is sq << 2*FRAC_BITS
	logic                c_v    [0:RW];
	logic [RAD_W-1:0]    c_rad  [0:RW];
	logic [RW+1:0]       c_rem  [0:RW];
	logic [RW-1:0]       c_root [0:RW];
	rv_pkg::rgb_t        c_rgb  [0:RW];

	assign c_v[0]    = v_s3;
	assign c_rad[0]  = RAD_W'({sq_s3, {(2 * FRAC_BITS){1'b0}}});
	assign c_rem[0]  = '0;
	assign c_root[0] = '0;
	assign c_rgb[0]  = rgb_s3;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		rv_sqrt_cell #(.RW(RW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_v      (c_v[g]),
			.in_rad    (c_rad[g]),
			.in_rem    (c_rem[g]),
			.in_root   (c_root[g]),
			.in_rgb    (c_rgb[g]),
			.out_v_q   (c_v[g+1]),
			.out_rad_q (c_rad[g+1]),
			.out_rem_q (c_rem[g+1]),
			.out_root_q(c_root[g+1]),
			.out_rgb_q (c_rgb[g+1])
		);
	end

	// Multiply stage: num = radius - dist, saturated at zero; product c * num
	logic [RADIUS_W-1:0]            radius, num;
	logic                           v_s4;
	logic [NCH-1:0][PROD_W-1:0]     prod_s4;

	assign radius = {height_q, {FRAC_BITS{1'b0}}};
	assign num    = (CMP_W'(c_root[RW]) < CMP_W'(radius))
	              ? radius - RADIUS_W'(c_root[RW]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= c_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NCH; i++) begin
			prod_s4[i] <= PROD_W'(c_rgb[RW][i]) * PROD_W'(num);
		end
	end

	// Quotient chain: quotient fits CH_W bits since num never exceeds radius.
	// A zero radius keeps every quotient bit clear, so the result is zero.
	logic                        d_v   [0:CH_W];
	logic [NCH-1:0][PROD_W-1:0]  d_rem [0:CH_W];
	rv_pkg::rgb_t                d_q   [0:CH_W];

	assign d_v[0]   = v_s4;
	assign d_rem[0] = prod_s4;
	assign d_q[0]   = '0;

	for (genvar j = 0; j < CH_W; j++) begin : g_div
		rv_div_cell #(
			.K    (CH_W - 1 - j),
			.N_W  (PROD_W),
			.DEN_W(RADIUS_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.den      (radius),
			.in_v     (d_v[j]),
			.in_rem   (d_rem[j]),
			.in_q     (d_q[j]),
			.out_v_q  (d_v[j+1]),
			.out_rem_q(d_rem[j+1]),
			.out_q_q  (d_q[j+1])
		);
	end

	assign done      = d_v[CH_W];
	assign red_out   = d_q[CH_W][0];
	assign green_out = d_q[CH_W][1];
	assign blue_out  = d_q[CH_W][2];

	// A result must trace back to a pixel taken earlier at the input
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching pixel");

	a_root_chain: assert property (@(posedge clk) disable iff (!arst_n)
		c_v[RW] |-> $past(c_v[0], RW))
		else $error("square root chain lost alignment");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		d_v[0] |-> $past(start, LAT - CH_W))
		else $error("quotient chain entered out of step");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for radial_vignette_pixel
// Drives pixels under several idle mixes and register settings, predicts
// each attenuated pixel and checks the words that leave in order.
// ----------------------------------------------------------------------------

class vignette_board;
	rv_pkg::rgb_t pending[$];
	int errors;
	logic [rv_pkg::REG_W-1:0] height_q;
	logic [rv_pkg::REG_W-1:0] width_q;

	function new();
		errors = 0;
		height_q = rv_pkg::HEIGHT_RST;
		width_q = rv_pkg::WIDTH_RST;
	endfunction

	// floor(sqrt(v)), one root bit per pass
	function automatic longint unsigned root_of(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function void note_pixel(logic [rv_pkg::IDX_W-1:0] row, logic [rv_pkg::IDX_W-1:0] col,
			rv_pkg::rgb_t px);
		longint unsigned cy, cx, dx, dy, dist_fx, radius, num;
		rv_pkg::rgb_t res;
		cy = height_q >> 1;
		cx = width_q >> 1;
		dx = (col >= cx) ? col - cx : cx - col;
		dy = (row >= cy) ? row - cy : cy - row;
		dist_fx = root_of((dx * dx + dy * dy) << 16);
		radius = longint'(height_q) << 8;
		num = (dist_fx < radius) ? radius - dist_fx : 0;
		for (int i = 0; i < rv_pkg::NCH; i++) begin
			if (radius == 0 || num == 0)
				res[i] = '0;
			else
				res[i] = rv_pkg::ch_t'((longint'(px[i]) * num) / radius);
		end
		pending.push_back(res);
	endfunction

	function void check_pixel(rv_pkg::rgb_t got);
		rv_pkg::rgb_t exp_px;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word %h", $time, got);
			errors++;
			return;
		end
		exp_px = pending.pop_front();
		for (int i = 0; i < rv_pkg::NCH; i++)
			if (got[i] !== exp_px[i]) begin
				$display("%0t: channel %0d expected %h actual %h", $time, i,
					exp_px[i], got[i]);
				errors++;
			end
	endfunction
endclass

module tb;
	localparam int IDX_W     = rv_pkg::IDX_W;
	localparam int CH_W      = rv_pkg::CH_W;
	localparam int REG_W     = rv_pkg::REG_W;
	localparam int CFG_IDX_W = rv_pkg::CFG_IDX_W;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [IDX_W-1:0] pixel_row = '0;
	logic [IDX_W-1:0] pixel_col = '0;
	logic [CH_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic done;
	logic [CH_W-1:0] red_out, green_out, blue_out;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = rv_pkg::REG_HEIGHT;
	logic [REG_W-1:0] cfg_wdata = '0;

	vignette_board board = new();
	int idle_pct = 0;

	radial_vignette_pixel DUT (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// check every word on the edge that ends its strobe cycle
	always @(posedge clk)
		if (arst_n && done)
			board.check_pixel({blue_out, green_out, red_out});

	// hold start until accepted; idle at random before each pixel
	task automatic send_pixel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
			logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		pixel_row <= row;
		pixel_col <= col;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_pixel(row, col, {b, g, r});
	endtask

	// drop start and drain the pipeline before touching the registers
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == rv_pkg::REG_HEIGHT)
			board.height_q = val;
		else
			board.width_q = val;
	endtask

	// random pixel: mostly inside the image, sometimes anywhere
	task automatic random_pixel();
		logic [IDX_W-1:0] row, col;
		if ($urandom_range(3) == 0) begin
			row = IDX_W'($urandom);
			col = IDX_W'($urandom);
		end else begin
			row = (board.height_q == 0) ? '0 : IDX_W'($urandom_range(board.height_q - 1));
			col = (board.width_q == 0) ? '0 : IDX_W'($urandom_range(board.width_q - 1));
		end
		send_pixel(row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
	endtask

	initial begin
		logic [REG_W-1:0] heights[6] = '{13'd480, 13'd1, 13'd0, 13'd8191, 13'd4096, 13'd37};
		logic [REG_W-1:0] widths[6]  = '{13'd640, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd100};
		int pcts[4] = '{0, 82, 0, 35};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: center, corners, extremes, beyond radius at reset sizes
		send_pixel(240, 320, 8'hff, 8'h80, 8'h01);
		send_pixel(0, 0, 8'hff, 8'hff, 8'hff);
		send_pixel(12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
		send_pixel(479, 639, 8'haa, 8'h55, 8'h00);
		send_pixel(240, 12'hfff, 8'hff, 8'hff, 8'hff);
		send_pixel(0, 320, 8'hff, 8'hff, 8'hff);
		send_pixel(240, 321, 8'h00, 8'hff, 8'h7f);
		drain();

		// zero height: every channel goes to zero
		write_reg(rv_pkg::REG_HEIGHT, 13'd0);
		send_pixel(0, 0, 8'hff, 8'hff, 8'hff);
		send_pixel(12'hfff, 12'h000, 8'hff, 8'h12, 8'h34);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rv_pkg::REG_HEIGHT, heights[ph]);
			write_reg(rv_pkg::REG_WIDTH, widths[ph]);
			idle_pct = pcts[ph % 4];
			for (int n = 0; n < 75; n++)
				random_pixel();
			// let the pipeline empty fully once mid-run
			if (ph == 1)
				drain();
			for (int n = 0; n < 3; n++)
				random_pixel();
			drain();
		end

		if (board.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#200000;
		$display("tb: done, errors");
		$finish;
	end
endmodule
